// ----- rtl/dll_pkg.sv -----
// shared types and constants for the doubly linked list engine
// no dependencies; used by doubly_linked_list_engine and the testbench
package dll_pkg;

  localparam int DefCapacity = 32;
  localparam int LenW        = 6;

  // command codes
  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL = 3'd1;
  localparam logic [2:0] CMD_INS_POS  = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [2:0] CMD_DEL_POS  = 3'd5;
  localparam logic [2:0] CMD_DUMP     = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [LenW-1:0]    length;
    logic               last;
  } out_t;

endpackage

// ----- rtl/dll_ram.sv -----
// single write port, single read port memory with registered read data
// no package dependencies; used for node values, links and the free stack
module dll_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/doubly_linked_list_engine.sv -----
// doubly linked list engine: ordered list of signed values in a slot pool
// depends on dll_pkg and dll_ram
//
//   channel  direction  payload          transfer when
//   in       input      dll_pkg::in_t    in_valid_i  && !in_stall_o
//   out      output     dll_pkg::out_t   out_valid_o && !out_stall_i
//
// head/tail insert and delete show their result from S_RESP once the link updates are written
// positional commands walk the forward links one memory read per cycle
// up to the anchor element, then update the links around it
// dump gives one result per cycle while out_stall_i is low, from the forward-link/value read port pair
// reset is immediate: the free stack uses a high-water mark, no clearing pass
// in_stall_o stays high while a command is in flight; a stalled result holds
module doubly_linked_list_engine #(
  parameter int CAPACITY = dll_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dll_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dll_pkg::out_t out_data_o
);

  localparam int SW  = $clog2(CAPACITY);     // slot index
  localparam int LKW = SW + 1;               // link, holds the null marker
  localparam int CW  = $clog2(CAPACITY + 1); // element count
  localparam int KW  = (CW > 8) ? CW : 8;    // position clamp arithmetic
  localparam logic [LKW-1:0] NULL_LINK = LKW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_HEAD2, S_WALK, S_AFTER, S_INS2, S_DEL_WR, S_DUMP_OUT, S_RESP
  } state_e;

  state_e state_q, state_d;

  // list bookkeeping
  logic [LKW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  hwm_q, hwm_d; // entries at or above this are unwritten, a pop there yields the count

  // command context
  logic [2:0]         cmd_q, cmd_d;
  logic [7:0]         pos_q, pos_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      k_q, k_d, i_q, i_d, dk_q, dk_d;
  logic [LKW-1:0]     cur_q, cur_d, nx_q, nx_d;
  logic [SW-1:0]      n_q, n_d, s_q, s_d;
  logic               pend_q, pend_d, byp_q, byp_d;
  logic [1:0]         res_q, res_d;

  // output register
  logic          out_valid_q, out_valid_d;
  dll_pkg::out_t out_q, out_d;

  // memory ports
  logic            val_we, val_re, fwd_we, fwd_re, bwd_we, bwd_re, free_we, free_re;
  logic [SW-1:0]   val_wa, val_ra, fwd_wa, fwd_ra, bwd_wa, bwd_ra, free_wa, free_ra;
  logic [31:0]     val_wd, val_rd;
  logic [LKW-1:0]  fwd_wd, fwd_rd, bwd_wd, bwd_rd;
  logic [SW-1:0]   free_wd, free_rd;

  dll_ram #(.Width(32), .Depth(CAPACITY)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(val_wd),
    .re_i(val_re), .raddr_i(val_ra), .rdata_o(val_rd)
  );
  dll_ram #(.Width(LKW), .Depth(CAPACITY)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_wa), .wdata_i(fwd_wd),
    .re_i(fwd_re), .raddr_i(fwd_ra), .rdata_o(fwd_rd)
  );
  dll_ram #(.Width(LKW), .Depth(CAPACITY)) u_bwd (
    .clk_i, .we_i(bwd_we), .waddr_i(bwd_wa), .wdata_i(bwd_wd),
    .re_i(bwd_re), .raddr_i(bwd_ra), .rdata_o(bwd_rd)
  );
  dll_ram #(.Width(SW), .Depth(CAPACITY)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(free_wa), .wdata_i(free_wd),
    .re_i(free_re), .raddr_i(free_ra), .rdata_o(free_rd)
  );

  logic [LKW-1:0] cur_eff;
  logic [KW-1:0]  kpos;
  logic [SW-1:0]  n_new;
  logic           out_free;
  logic           head_ins, head_del, dump_last;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    hwm_d       = hwm_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    k_d         = k_q;
    i_d         = i_q;
    dk_d        = dk_q;
    cur_d       = cur_q;
    nx_d        = nx_q;
    n_d         = n_q;
    s_d         = s_q;
    pend_d      = pend_q;
    byp_d       = byp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    val_we = 1'b0; val_re = 1'b0; fwd_we = 1'b0; fwd_re = 1'b0;
    bwd_we = 1'b0; bwd_re = 1'b0; free_we = 1'b0; free_re = 1'b0;
    val_wa = '0; val_ra = '0; fwd_wa = '0; fwd_ra = '0;
    bwd_wa = '0; bwd_ra = '0; free_wa = '0; free_ra = '0;
    val_wd = '0; fwd_wd = '0; bwd_wd = '0; free_wd = '0;

    // walk position: chained reads take the link straight from the memory
    cur_eff  = pend_q ? fwd_rd : cur_q;
    out_free = !out_valid_q || !out_stall_i;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // anchor index clamp(position-1, 1, length)
    kpos = (in_data_i.position >= 8'd2) ? (KW'(in_data_i.position) - KW'(1)) : KW'(1);
    if (kpos > KW'(cnt_q)) begin
      kpos = KW'(cnt_q);
    end

    head_ins  = (cmd_q == dll_pkg::CMD_INS_HEAD) ||
                ((cmd_q == dll_pkg::CMD_INS_POS) && (pos_q == 8'd1));
    head_del  = (in_data_i.cmd == dll_pkg::CMD_DEL_HEAD) ||
                ((in_data_i.cmd == dll_pkg::CMD_DEL_POS) && (in_data_i.position == 8'd1));
    n_new     = byp_q ? SW'(cnt_q) : free_rd;
    dump_last = ((dk_q + CW'(1)) == cnt_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_data_i.cmd;
          pos_d  = in_data_i.position;
          val_d  = in_data_i.value;
          k_d    = CW'(kpos);
          i_d    = CW'(1);
          cur_d  = head_q;
          pend_d = 1'b0;
          res_d  = dll_pkg::ST_OK;
          if (in_data_i.cmd <= dll_pkg::CMD_INS_POS) begin
            if (cnt_q == CW'(CAPACITY)) begin
              res_d   = dll_pkg::ST_FULL;
              state_d = S_RESP;
            end else begin
              // pop the free stack
              free_re = 1'b1;
              free_ra = SW'(cnt_q);
              byp_d   = (cnt_q >= hwm_q);
              state_d = S_ALLOC;
            end
          end else if (in_data_i.cmd <= dll_pkg::CMD_DEL_POS) begin
            if (cnt_q == '0) begin
              res_d   = dll_pkg::ST_EMPTY;
              state_d = S_RESP;
            end else if (head_del || (in_data_i.cmd == dll_pkg::CMD_DEL_TAIL)) begin
              s_d     = head_del ? SW'(head_q) : SW'(tail_q);
              fwd_re  = 1'b1;
              bwd_re  = 1'b1;
              fwd_ra  = s_d;
              bwd_ra  = s_d;
              state_d = S_DEL_WR;
            end else begin
              state_d = S_WALK;
            end
          end else if (in_data_i.cmd == dll_pkg::CMD_DUMP) begin
            if (cnt_q == '0) begin
              res_d   = dll_pkg::ST_EMPTY;
              state_d = S_RESP;
            end else begin
              val_re  = 1'b1;
              fwd_re  = 1'b1;
              val_ra  = SW'(head_q);
              fwd_ra  = SW'(head_q);
              dk_d    = '0;
              state_d = S_DUMP_OUT;
            end
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_ALLOC: begin
        n_d   = n_new;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q >= hwm_q) begin
          hwm_d = cnt_q + CW'(1);
        end
        if (cnt_q == '0) begin
          // only element
          val_we  = 1'b1; val_wa = n_new; val_wd = val_q;
          fwd_we  = 1'b1; fwd_wa = n_new; fwd_wd = NULL_LINK;
          bwd_we  = 1'b1; bwd_wa = n_new; bwd_wd = NULL_LINK;
          head_d  = LKW'(n_new);
          tail_d  = LKW'(n_new);
          state_d = S_RESP;
        end else if (head_ins) begin
          val_we  = 1'b1; val_wa = n_new; val_wd = val_q;
          fwd_we  = 1'b1; fwd_wa = n_new; fwd_wd = head_q;
          bwd_we  = 1'b1; bwd_wa = n_new; bwd_wd = NULL_LINK;
          state_d = S_HEAD2;
        end else if (cmd_q == dll_pkg::CMD_INS_TAIL) begin
          // anchor is the tail, no walk steps
          cur_d   = tail_q;
          k_d     = CW'(1);
          i_d     = CW'(1);
          state_d = S_WALK;
        end else begin
          state_d = S_WALK;
        end
      end

      S_HEAD2: begin
        bwd_we  = 1'b1;
        bwd_wa  = SW'(head_q);
        bwd_wd  = LKW'(n_q);
        head_d  = LKW'(n_q);
        state_d = S_RESP;
      end

      S_WALK: begin
        fwd_re = 1'b1;
        fwd_ra = SW'(cur_eff);
        if (i_q < k_q) begin
          pend_d = 1'b1;
          i_d    = i_q + CW'(1);
        end else begin
          // anchor found, its forward link arrives next cycle
          cur_d   = cur_eff;
          pend_d  = 1'b0;
          state_d = S_AFTER;
        end
      end

      S_AFTER: begin
        if (cmd_q <= dll_pkg::CMD_INS_POS) begin
          val_we  = 1'b1; val_wa = n_q; val_wd = val_q;
          fwd_we  = 1'b1; fwd_wa = n_q; fwd_wd = fwd_rd;
          bwd_we  = 1'b1; bwd_wa = n_q; bwd_wd = cur_q;
          nx_d    = fwd_rd;
          state_d = S_INS2;
        end else if (fwd_rd >= NULL_LINK) begin
          res_d   = dll_pkg::ST_BADPOS;
          state_d = S_RESP;
        end else begin
          s_d     = SW'(fwd_rd);
          fwd_re  = 1'b1;
          bwd_re  = 1'b1;
          fwd_ra  = SW'(fwd_rd);
          bwd_ra  = SW'(fwd_rd);
          state_d = S_DEL_WR;
        end
      end

      S_INS2: begin
        fwd_we = 1'b1;
        fwd_wa = SW'(cur_q);
        fwd_wd = LKW'(n_q);
        if (nx_q < NULL_LINK) begin
          bwd_we = 1'b1;
          bwd_wa = SW'(nx_q);
          bwd_wd = LKW'(n_q);
        end else begin
          tail_d = LKW'(n_q);
        end
        state_d = S_RESP;
      end

      S_DEL_WR: begin
        // bridge the neighbors and push the slot back on the free stack
        if (bwd_rd < NULL_LINK) begin
          fwd_we = 1'b1;
          fwd_wa = SW'(bwd_rd);
          fwd_wd = fwd_rd;
        end else begin
          head_d = fwd_rd;
        end
        if (fwd_rd < NULL_LINK) begin
          bwd_we = 1'b1;
          bwd_wa = SW'(fwd_rd);
          bwd_wd = bwd_rd;
        end else begin
          tail_d = bwd_rd;
        end
        cnt_d   = cnt_q - CW'(1);
        free_we = 1'b1;
        free_wa = SW'(cnt_q - CW'(1));
        free_wd = s_q;
        state_d = S_RESP;
      end

      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = dll_pkg::ST_OK;
          out_d.element   = val_rd;
          out_d.length    = dll_pkg::LenW'(cnt_q);
          out_d.last      = dump_last;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            dk_d   = dk_q + CW'(1);
            val_re = 1'b1;
            fwd_re = 1'b1;
            val_ra = SW'(fwd_rd);
            fwd_ra = SW'(fwd_rd);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = res_q;
          out_d.element = '0;
          out_d.length  = dll_pkg::LenW'(cnt_q);
          out_d.last    = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_LINK;
      tail_q      <= NULL_LINK;
      cnt_q       <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      dk_q        <= '0;
      cur_q       <= '0;
      nx_q        <= '0;
      n_q         <= '0;
      s_q         <= '0;
      pend_q      <= 1'b0;
      byp_q       <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      k_q         <= k_d;
      i_q         <= i_d;
      dk_q        <= dk_d;
      cur_q       <= cur_d;
      nx_q        <= nx_d;
      n_q         <= n_d;
      s_q         <= s_d;
      pend_q      <= pend_d;
      byp_q       <= byp_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // count never exceeds the pool
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  // the high-water mark never falls below the count
  a_hwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q >= cnt_q)
    else $error("high-water mark below count");

  // empty list and null head agree between commands
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == NULL_LINK) == (cnt_q == '0)))
    else $error("head and count disagree");

  // head and tail are null together between commands
  a_tail_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == NULL_LINK) == (tail_q == NULL_LINK)))
    else $error("head and tail disagree");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for doubly_linked_list_engine
// depends on dll_pkg and the engine rtl; predicts every result from its own list model
module tb_top;

  localparam int Cap = dll_pkg::DefCapacity;
  localparam int CycleLimit = 1000000;
  localparam logic [2:0] CmdUnused = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  dll_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  dll_pkg::out_t out_data_o;

  doubly_linked_list_engine dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow list: plain ordered queue is enough, slots are invisible outside
  logic signed [31:0] shadow_list[$];
  dll_pkg::out_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit hold_off;          // long receiver hold-off request
  bit random_stall_en;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // anchor index (0-based) for positional commands: clamp(pos-1, 1, length) - 1
  function automatic int anchor_index(input logic [7:0] pos);
    int k;
    k = (pos >= 2) ? int'(pos) - 1 : 1;
    if (k > shadow_list.size()) k = shadow_list.size();
    return k - 1;
  endfunction

  function automatic dll_pkg::out_t make_result(input logic [1:0] st, input logic [31:0] el,
                                                input bit fin);
    dll_pkg::out_t r;
    r.status = st;
    r.element = el;
    r.length = dll_pkg::LenW'(shadow_list.size());
    r.last = fin;
    return r;
  endfunction

  // applies one command to the shadow list and queues what the engine must emit
  task automatic predict_list_op(input dll_pkg::in_t item);
    logic [1:0] st;
    int a;
    st = dll_pkg::ST_OK;
    case (item.cmd)
      dll_pkg::CMD_INS_HEAD, dll_pkg::CMD_INS_TAIL, dll_pkg::CMD_INS_POS: begin
        if (shadow_list.size() >= Cap) st = dll_pkg::ST_FULL;
        else if (shadow_list.size() == 0) shadow_list.push_back(item.value);
        else if (item.cmd == dll_pkg::CMD_INS_HEAD ||
                 (item.cmd == dll_pkg::CMD_INS_POS && item.position == 8'd1))
          shadow_list.push_front(item.value);
        else if (item.cmd == dll_pkg::CMD_INS_TAIL) shadow_list.push_back(item.value);
        else shadow_list.insert(anchor_index(item.position) + 1, item.value);
      end
      dll_pkg::CMD_DEL_HEAD, dll_pkg::CMD_DEL_TAIL, dll_pkg::CMD_DEL_POS: begin
        if (shadow_list.size() == 0) st = dll_pkg::ST_EMPTY;
        else if (item.cmd == dll_pkg::CMD_DEL_HEAD ||
                 (item.cmd == dll_pkg::CMD_DEL_POS && item.position == 8'd1))
          void'(shadow_list.pop_front());
        else if (item.cmd == dll_pkg::CMD_DEL_TAIL) void'(shadow_list.pop_back());
        else begin
          a = anchor_index(item.position);
          if (a + 1 < shadow_list.size()) shadow_list.delete(a + 1);
          else st = dll_pkg::ST_BADPOS;
        end
      end
      dll_pkg::CMD_DUMP: begin
        if (shadow_list.size() == 0)
          pending_results.push_back(make_result(dll_pkg::ST_EMPTY, 32'd0, 1'b1));
        foreach (shadow_list[i])
          pending_results.push_back(make_result(dll_pkg::ST_OK, shadow_list[i],
                                                i == shadow_list.size() - 1));
        return;
      end
      default: ;  // unused code: ignored, plain ok result
    endcase
    pending_results.push_back(make_result(st, 32'd0, 1'b1));
  endtask

  // sends one command; gap drawn per item, then waits for the transfer
  // valid stays up after the transfer and drops only when a gap follows or the bench waits to drain
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] pos,
                          input logic [31:0] val, input bit use_gap = 1'b1);
    dll_pkg::in_t item;
    int gap;
    item.cmd = cmd;
    item.position = pos;
    item.value = val;
    gap = use_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_list_op(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver: per-result stall draw, plus the long hold-off
  initial begin
    int wait_cycles;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_cycles = random_stall_en ? $urandom_range(0, 17) : 0;
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker, samples at the transfer edge
  always @(posedge clk_i) begin
    dll_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.element, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.element !== want.element)
          report_mismatch("element", out_data_o.element, want.element);
        if (out_data_o.length !== want.length)
          report_mismatch("length", 32'(out_data_o.length), 32'(want.length));
        if (out_data_o.last !== want.last)
          report_mismatch("last", 32'(out_data_o.last), 32'(want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout");
      $display("Verification failed");
      $finish;
    end
  end

  // empty-list corners: deletes, dump and positional ops on nothing
  task automatic test_empty_list();
    send_cmd(dll_pkg::CMD_DEL_HEAD, 8'd0, 32'd0);
    send_cmd(dll_pkg::CMD_DEL_TAIL, 8'd0, 32'd0);
    send_cmd(dll_pkg::CMD_DEL_POS, 8'd1, 32'd0);
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0);
    send_cmd(dll_pkg::CMD_INS_POS, 8'd255, 32'h8000_0000);  // only element
    send_cmd(dll_pkg::CMD_DEL_POS, 8'd0, 32'd0);            // nothing after head: bad position
    send_cmd(CmdUnused, 8'hff, 32'hffff_ffff);              // unused code
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0);
  endtask

  // every command but CMD_DEL_HEAD, with edge positions and extreme values
  task automatic test_positions();
    send_cmd(dll_pkg::CMD_INS_HEAD, 8'd0, 32'h7fff_ffff);
    send_cmd(dll_pkg::CMD_INS_TAIL, 8'd0, 32'h0000_0000);
    send_cmd(dll_pkg::CMD_INS_POS, 8'd1, 32'hffff_ffff);
    send_cmd(dll_pkg::CMD_INS_POS, 8'd0, 32'h5555_5555);
    send_cmd(dll_pkg::CMD_INS_POS, 8'd3, 32'haaaa_aaaa);
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0);
    send_cmd(dll_pkg::CMD_DEL_POS, 8'd2, 32'd0);
    send_cmd(dll_pkg::CMD_DEL_POS, 8'd200, 32'd0);          // past the end
    send_cmd(dll_pkg::CMD_DEL_TAIL, 8'd0, 32'd0);
    send_cmd(dll_pkg::CMD_DEL_POS, 8'd1, 32'd0);
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0);
  endtask

  // fill the pool past capacity, dump a full list, then drain it
  task automatic test_pool_full();
    while (shadow_list.size() < Cap)
      send_cmd(3'($urandom_range(0, 2)), 8'($urandom), $urandom, 1'b0);
    send_cmd(dll_pkg::CMD_INS_TAIL, 8'd0, 32'h1234_5678);
    send_cmd(dll_pkg::CMD_INS_POS, 8'd5, 32'h1);
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0);
    while (shadow_list.size() > 0)
      send_cmd(3'($urandom_range(3, 5)), 8'($urandom_range(0, 3)), $urandom, 1'b0);
  endtask

  // receiver holds off while commands keep coming, so the engine backs up
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (6) send_cmd(3'($urandom_range(0, 2)), 8'($urandom), $urandom, 1'b0);
    send_cmd(dll_pkg::CMD_DUMP, 8'd0, 32'd0, 1'b0);
    wait_drained();  // sender pauses until everything is back
  endtask

  // random mix; positions kept mostly within the list so walks reach far
  task automatic test_random_mix(input int count);
    logic [2:0] cmd;
    logic [7:0] pos;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) cmd = 3'($urandom_range(0, 2));
      else if (r < 85) cmd = 3'($urandom_range(3, 5));
      else if (r < 97) cmd = dll_pkg::CMD_DUMP;
      else cmd = CmdUnused;
      pos = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                        : 8'($urandom_range(0, shadow_list.size() + 1));
      send_cmd(cmd, pos, $urandom);
      if (i == count / 2) random_stall_en = 1'b0;      // stretch with no receiver stalls
      if (i == count / 2 + 20) random_stall_en = 1'b1;
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    random_stall_en = 1'b1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_positions();
    test_backpressure();
    test_pool_full();
    test_random_mix(90);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
